// File: rtl/spcf_pkg.sv
// Package for the strip peak cluster finder.
// Result word, accumulator and result bundle types, kind codes and sizes.
// No dependencies.
`default_nettype none
package spcf_pkg;

  localparam int MAX_STRIPS_DEF = 128;
  localparam int ENERGY_W = 13;
  localparam int THR_W = 16;
  localparam int IDX_W = 8;
  localparam int ESUM_W = 16;
  localparam int WSUM_W = 32;
  localparam int BUNDLE_DEPTH = 3;

  localparam logic KIND_RECORD = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  typedef struct packed {
    logic              kind;
    logic [IDX_W-1:0]  slot;
    logic [IDX_W-1:0]  first;
    logic [IDX_W-1:0]  count;
    logic [ESUM_W-1:0] esum;
    logic [WSUM_W-1:0] wsum;
    logic [IDX_W-1:0]  npk;
  } result_t;

  typedef struct packed {
    logic              open;
    logic [IDX_W-1:0]  start;
    logic [IDX_W-1:0]  len;
    logic [ESUM_W-1:0] eacc;
    logic [WSUM_W-1:0] wacc;
    logic [IDX_W-1:0]  npk;
  } acc_t;

  typedef struct packed {
    acc_t    acc;
    result_t rec;
    logic    emit;
  } settle_t;

  typedef struct packed {
    result_t [BUNDLE_DEPTH-1:0] res;
    logic [1:0]                 cnt;
  } bundle_t;

endpackage
`default_nettype wire

// File: rtl/spcf_core.sv
// Peak finder core: threshold register, layer state and per-strip settle logic.
// Builds the bundle of up to three result words for the strip at its input.
// Depends on spcf_pkg.
`default_nettype none
module spcf_core #(
  parameter int MAX_STRIPS = spcf_pkg::MAX_STRIPS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              cfg_wr_en,
  input  wire logic [spcf_pkg::THR_W-1:0]        cfg_wr_data,
  input  wire logic                              step_en,
  input  wire logic [spcf_pkg::ENERGY_W-1:0]     strip_energy,
  input  wire logic                              layer_end,
  output spcf_pkg::bundle_t                      bundle
);

  localparam logic [spcf_pkg::IDX_W-1:0] LastPos = spcf_pkg::IDX_W'(MAX_STRIPS - 1);

  logic [spcf_pkg::THR_W-1:0]    thr_r;
  logic [spcf_pkg::ENERGY_W-1:0] eb1_r, eb1_nxt;
  logic [spcf_pkg::ENERGY_W-1:0] eb2_r, eb2_nxt;
  logic                          pend_r, pend_nxt;
  logic [spcf_pkg::IDX_W-1:0]    pos_r, pos_nxt;
  spcf_pkg::acc_t                acc_r, acc_nxt;

  function automatic logic [spcf_pkg::THR_W:0] ext(input logic [spcf_pkg::ENERGY_W:0] v);
    ext = (spcf_pkg::THR_W+1)'(v);
  endfunction

  function automatic logic [spcf_pkg::ENERGY_W:0] x125(
    input logic [spcf_pkg::ENERGY_W-1:0] v);
    x125 = {1'b0, v} + {3'b000, v[spcf_pkg::ENERGY_W-1:2]};
  endfunction

  // valley test shared by open and close conditions
  function automatic logic valley(input logic [spcf_pkg::ENERGY_W-1:0] p,
                                  input logic [spcf_pkg::ENERGY_W-1:0] e,
                                  input logic [spcf_pkg::ENERGY_W-1:0] n);
    logic [spcf_pkg::ENERGY_W:0] ex;
    ex = x125(e);
    valley = (p > e && ex < {1'b0, n}) || ({1'b0, p} > ex && e < n);
  endfunction

  function automatic spcf_pkg::settle_t settle(
    input spcf_pkg::acc_t               a,
    input logic [spcf_pkg::IDX_W-1:0]   slot,
    input logic [spcf_pkg::ENERGY_W-1:0] e,
    input logic                         op,
    input logic                         cl);
    spcf_pkg::settle_t s;
    logic       member;
    logic [8:0] w;
    logic [21:0] prod;
    s = '0;
    s.acc = a;
    member = a.open | op | cl;
    w = {1'b0, a.len} + 9'd1;
    prod = 22'(w) * 22'(e);
    if (op) begin
      s.acc.start = slot;
      s.acc.open = 1'b1;
    end
    if (cl) begin
      s.acc.open = 1'b0;
    end
    if (member) begin
      s.acc.wacc = a.wacc + spcf_pkg::WSUM_W'(prod);
      s.acc.len = a.len + 8'd1;
      s.acc.eacc = a.eacc + spcf_pkg::ESUM_W'(e);
    end
    s.rec.kind = spcf_pkg::KIND_RECORD;
    s.rec.slot = slot;
    s.rec.first = s.acc.start;
    s.rec.count = s.acc.len;
    s.rec.esum = s.acc.eacc;
    s.rec.wsum = s.acc.wacc;
    s.rec.npk = '0;
    s.emit = cl;
    if (cl) begin
      if (s.acc.eacc != '0) begin
        s.acc.npk = s.acc.npk + 8'd1;
      end
      s.acc.start = '0;
      s.acc.len = '0;
      s.acc.eacc = '0;
      s.acc.wacc = '0;
    end
    settle = s;
  endfunction

  logic [spcf_pkg::THR_W:0] thr_x;
  logic                     last;
  logic                     cur_opens;
  logic                     prev_closes;
  logic                     cur_closes;
  logic                     v1, v2, v3;
  spcf_pkg::settle_t        s1, s2;
  spcf_pkg::acc_t           a1;
  spcf_pkg::result_t        summ;

  always_comb begin
    thr_x = {1'b0, thr_r};
    last = layer_end || (pos_r >= LastPos);
    cur_opens = (ext({1'b0, eb1_r}) <= thr_x && ext({1'b0, strip_energy}) > thr_x) ||
                valley(eb2_r, eb1_r, strip_energy);
    prev_closes = (ext({1'b0, eb1_r}) > thr_x) &&
                  (ext({1'b0, strip_energy}) <= thr_x || valley(eb2_r, eb1_r, strip_energy));
    cur_closes = ext({1'b0, strip_energy}) > thr_x;

    s1 = settle(acc_r, pos_r - 8'd1, eb1_r, pend_r, prev_closes);
    a1 = (pos_r != '0) ? s1.acc : acc_r;
    v1 = (pos_r != '0) && s1.emit;
    s2 = settle(a1, pos_r, strip_energy, cur_opens, cur_closes);
    v2 = last && s2.emit;
    v3 = last;

    summ = '0;
    summ.kind = spcf_pkg::KIND_SUMMARY;
    summ.npk = s2.acc.npk;

    bundle.res[0] = v1 ? s1.rec : (v2 ? s2.rec : summ);
    bundle.res[1] = (v1 && v2) ? s2.rec : summ;
    bundle.res[2] = summ;
    bundle.cnt = 2'(v1) + 2'(v2) + 2'(v3);

    if (last) begin
      eb1_nxt = '0;
      eb2_nxt = '0;
      pend_nxt = 1'b0;
      pos_nxt = '0;
      acc_nxt = '0;
    end else begin
      eb1_nxt = strip_energy;
      eb2_nxt = eb1_r;
      pend_nxt = cur_opens;
      pos_nxt = pos_r + 8'd1;
      acc_nxt = a1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= '0;
      eb1_r <= '0;
      eb2_r <= '0;
      pend_r <= 1'b0;
      pos_r <= '0;
      acc_r <= '0;
    end else begin
      if (cfg_wr_en) begin
        thr_r <= cfg_wr_data;
      end
      if (step_en) begin
        eb1_r <= eb1_nxt;
        eb2_r <= eb2_nxt;
        pend_r <= pend_nxt;
        pos_r <= pos_nxt;
        acc_r <= acc_nxt;
      end
    end
  end

endmodule
`default_nettype wire

// File: rtl/spcf_outbuf.sv
// Output buffer: holds the result words of one strip and hands them out one
// word per cycle while out_ready is high. Depends on spcf_pkg.
`default_nettype none
module spcf_outbuf (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               load,
  input  wire spcf_pkg::bundle_t  bundle_in,
  input  wire logic               out_ready,
  output logic                    out_valid,
  output logic                    out_last,
  output logic                    free_nxt,
  output spcf_pkg::result_t       res
);

  spcf_pkg::bundle_t bund_r;
  logic [1:0]        cnt_r;
  logic [1:0]        idx_r;
  logic              take;

  always_comb begin
    out_valid = (cnt_r != 2'd0);
    out_last = (idx_r == cnt_r - 2'd1);
    take = out_valid && out_ready;
    free_nxt = !out_valid || (take && out_last);
    case (idx_r)
      2'd0: res = bund_r.res[0];
      2'd1: res = bund_r.res[1];
      2'd2: res = bund_r.res[2];
      default: res = bund_r.res[0];
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
      idx_r <= 2'd0;
    end else if (load) begin
      cnt_r <= bundle_in.cnt;
      idx_r <= 2'd0;
    end else if (take) begin
      if (out_last) begin
        cnt_r <= 2'd0;
        idx_r <= 2'd0;
      end else begin
        idx_r <= idx_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      bund_r <= bundle_in;
    end
  end

endmodule
`default_nettype wire

// File: rtl/strip_peak_cluster_finder.sv
// Strip peak cluster finder, top level. Strips and result words are registered.
// Throughput: one strip per cycle when it yields at most one result word and
// out_ready is high; a strip yielding more words holds the output buffer until
// its last word is taken. Reset (rst_n low, synchronous) clears threshold, layer
// state and both handshakes. Depends on spcf_pkg, spcf_core, spcf_outbuf.
`default_nettype none
module strip_peak_cluster_finder #(
  parameter int MAX_STRIPS = spcf_pkg::MAX_STRIPS_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             cfg_wr_en,
  input  wire logic [spcf_pkg::THR_W-1:0]       cfg_wr_data,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire logic [spcf_pkg::ENERGY_W-1:0]    in_strip_energy,
  input  wire logic                             in_layer_end,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output logic                                  out_item_kind,
  output logic [spcf_pkg::IDX_W-1:0]            out_peak_slot,
  output logic [spcf_pkg::IDX_W-1:0]            out_first_strip,
  output logic [spcf_pkg::IDX_W-1:0]            out_strip_count,
  output logic [spcf_pkg::ESUM_W-1:0]           out_energy_sum,
  output logic [spcf_pkg::WSUM_W-1:0]           out_weighted_sum,
  output logic [spcf_pkg::IDX_W-1:0]            out_peak_count,
  output logic                                  out_run_last
);

  logic                          in_valid_r;
  logic [spcf_pkg::ENERGY_W-1:0] energy_r;
  logic                          end_r;
  logic                          step_en;
  logic                          free_nxt;
  spcf_pkg::bundle_t             bundle;
  spcf_pkg::result_t             res;

  assign step_en = in_valid_r && free_nxt;
  assign in_ready = !in_valid_r || step_en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      energy_r <= in_strip_energy;
      end_r <= in_layer_end;
    end
  end

  spcf_core #(
    .MAX_STRIPS(MAX_STRIPS)
  ) u_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .step_en      (step_en),
    .strip_energy (energy_r),
    .layer_end    (end_r),
    .bundle       (bundle)
  );

  spcf_outbuf u_outbuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (step_en && (bundle.cnt != 2'd0)),
    .bundle_in (bundle),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_last  (out_run_last),
    .free_nxt  (free_nxt),
    .res       (res)
  );

  assign out_item_kind = res.kind;
  assign out_peak_slot = res.slot;
  assign out_first_strip = res.first;
  assign out_strip_count = res.count;
  assign out_energy_sum = res.esum;
  assign out_weighted_sum = res.wsum;
  assign out_peak_count = res.npk;

endmodule
`default_nettype wire

// File: rtl/spcf_checker.sv
// Port-level checker for strip_peak_cluster_finder, bound to the top level.
// Depends on spcf_pkg.
`default_nettype none
module spcf_checker (
  input wire logic                          clk,
  input wire logic                          rst_n,
  input wire logic                          out_valid,
  input wire logic                          out_ready,
  input wire logic                          out_item_kind,
  input wire logic [spcf_pkg::IDX_W-1:0]    out_peak_slot,
  input wire logic [spcf_pkg::IDX_W-1:0]    out_first_strip,
  input wire logic [spcf_pkg::IDX_W-1:0]    out_strip_count,
  input wire logic [spcf_pkg::ESUM_W-1:0]   out_energy_sum,
  input wire logic [spcf_pkg::WSUM_W-1:0]   out_weighted_sum,
  input wire logic [spcf_pkg::IDX_W-1:0]    out_peak_count,
  input wire logic                          out_run_last
);

  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out_valid high after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_item_kind) &&
      $stable(out_energy_sum) && $stable(out_weighted_sum) && $stable(out_run_last))
    else $error("stalled result word changed");

  a_summary_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item_kind == spcf_pkg::KIND_SUMMARY |-> out_run_last)
    else $error("layer summary not last word of its strip");

  a_summary_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item_kind == spcf_pkg::KIND_SUMMARY |->
      out_peak_slot == '0 && out_first_strip == '0 && out_strip_count == '0 &&
      out_energy_sum == '0 && out_weighted_sum == '0)
    else $error("layer summary carries peak fields");

  a_record_npk: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item_kind == spcf_pkg::KIND_RECORD |-> out_peak_count == '0)
    else $error("peak record carries a peak count");

endmodule

bind strip_peak_cluster_finder spcf_checker u_spcf_checker (.*);
`default_nettype wire
